// ===== rtl/dtm_pkg.sv =====
// Shared types, codes and helpers for the DNS transaction match table.
// Used by the core, controller and datapath; no dependencies.
package dtm_pkg;

    // Default table sizes
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int TOMB_ENTRIES_DEF  = 16;

    // Configuration reset values
    localparam logic [4:0]  LIMIT_RST   = 5'd16;
    localparam logic [31:0] TIMEOUT_RST = 32'd5000000;
    localparam logic [31:0] KEEP_RST    = 32'd15000000;

    // Configuration register indexes (byte address / 4)
    localparam logic [1:0] REG_LIMIT   = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_KEEP    = 2'd2;

    // Request opcodes
    localparam logic [2:0] OP_QUERY    = 3'd0;
    localparam logic [2:0] OP_RESPONSE = 3'd1;
    localparam logic [2:0] OP_SWEEP    = 3'd2;
    localparam logic [2:0] OP_EPOCH    = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;

    // Result kinds
    localparam logic [3:0] KIND_NEW       = 4'd0;
    localparam logic [3:0] KIND_RETRY     = 4'd1;
    localparam logic [3:0] KIND_FULL      = 4'd2;
    localparam logic [3:0] KIND_NOERROR   = 4'd3;
    localparam logic [3:0] KIND_SERVFAIL  = 4'd4;
    localparam logic [3:0] KIND_NXDOMAIN  = 4'd5;
    localparam logic [3:0] KIND_REFUSED   = 4'd6;
    localparam logic [3:0] KIND_TRUNC     = 4'd7;
    localparam logic [3:0] KIND_OTHER     = 4'd8;
    localparam logic [3:0] KIND_LATE      = 4'd9;
    localparam logic [3:0] KIND_UNMATCHED = 4'd10;
    localparam logic [3:0] KIND_AMBIG     = 4'd11;
    localparam logic [3:0] KIND_TIMEOUT   = 4'd12;
    localparam logic [3:0] KIND_SWEEPDONE = 4'd13;
    localparam logic [3:0] KIND_EPOCH_ADV = 4'd14;
    localparam logic [3:0] KIND_EPOCH_IGN = 4'd15;

    // DNS rcodes with a kind of their own
    localparam logic [3:0] RCODE_NOERROR  = 4'd0;
    localparam logic [3:0] RCODE_SERVFAIL = 4'd2;
    localparam logic [3:0] RCODE_NXDOMAIN = 4'd3;
    localparam logic [3:0] RCODE_REFUSED  = 4'd5;

    // Datapath actions; each but ACT_NONE loads one result
    typedef logic [3:0] t_act;
    localparam t_act ACT_NONE    = 4'd0;
    localparam t_act ACT_RETRY   = 4'd1;
    localparam t_act ACT_FULL    = 4'd2;
    localparam t_act ACT_NEW     = 4'd3;
    localparam t_act ACT_RESP    = 4'd4;
    localparam t_act ACT_AMBIG   = 4'd5;
    localparam t_act ACT_TOMBRES = 4'd6;
    localparam t_act ACT_SWPUT   = 4'd7;
    localparam t_act ACT_SWDONE  = 4'd8;
    localparam t_act ACT_EPOCH   = 4'd9;
    localparam t_act ACT_CLEAR   = 4'd10;

    typedef struct packed {
        logic [15:0] txid;
        logic [31:0] res;
        logic [31:0] cli;
        logic [15:0] port;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic [47:0] first;
        logic [15:0] att;
        logic        part;
        logic [31:0] gen;
    } t_entry;

    typedef struct packed {
        t_key        key;
        logic [47:0] ts;
    } t_tomb;

    // Controller to datapath
    typedef struct packed {
        t_act act;
        logic cap;
        logic e_scan;
        logic t_scan;
        logic prune;
        logic key_ex;
        logic sw_rd;
        logic sw_cap;
        logic sw_inc;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic e_done;
        logic t_done;
        logic ex_hit;
        logic cand_one;
        logic cand_multi;
        logic full;
        logic expire;
        logic sw_last;
    } t_sts;

    // Zero on either side is a wildcard
    function automatic logic field_ok(input logic [31:0] q, input logic [31:0] e);
        return (q == 32'd0) || (e == 32'd0) || (q == e);
    endfunction

    // Age clamped at zero
    function automatic logic [47:0] age_of(input logic [47:0] now, input logic [47:0] first);
        return (now >= first) ? (now - first) : 48'd0;
    endfunction

endpackage

// ===== rtl/dns_transaction_match_table_core.sv =====
// Top level of the DNS transaction match table: register port, controller
// and datapath. Depends on dtm_pkg, dtm_ctrl, dtm_datapath and dtm_ram.
//
// Usage:
//   Requests (query, response, sweep, epoch advance, clear) enter on the
//   i_in_valid / o_in_stall channel; results leave on o_out_valid /
//   i_out_stall, one or more per request, o_last marking the final one.
//   One request is worked at a time; o_in_stall is high while it is.
//   A query or response scans the entry table and, if that decides nothing,
//   the tombstone table; a sweep prunes the tombstones, then reads the
//   entries one by one and scans the tombstones once per expired entry.
//   Every scan reads one entry per cycle from a single RAM read port.
//   The last result sits in an output register, so the next request is
//   taken while it waits. A stalled receiver holds the result and stops the
//   sequencer before the next one. Reset empties both tables, clears the
//   epoch and insert counter and loads the default register values; there
//   is no clearing pass. Registers sit at byte addresses 0, 4, 8 (APB).
module dns_transaction_match_table_core #(
    parameter int TABLE_ENTRIES = dtm_pkg::TABLE_ENTRIES_DEF,
    parameter int TOMB_ENTRIES  = dtm_pkg::TOMB_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_txid,
    input  logic [31:0] i_resolver_addr,
    input  logic [31:0] i_client_addr,
    input  logic [15:0] i_client_port_num,
    input  logic        i_partial_quality,
    input  logic [3:0]  i_rcode,
    input  logic        i_truncated,
    input  logic        i_malformed,
    input  logic [47:0] i_now_us,
    input  logic [31:0] i_new_epoch,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_kind,
    output logic [15:0] o_match_txid,
    output logic [47:0] o_latency_us,
    output logic [15:0] o_attempts,
    output logic [31:0] o_generation,
    output logic        o_partial_match,
    output logic [4:0]  o_expired_count,
    output logic        o_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dtm_pkg::*;

    logic [4:0]  r_active_limit;
    logic [31:0] r_query_timeout_us;
    logic [31:0] r_tombstone_keep_us;
    logic        cfg_wr;
    t_cmd        cmd;
    t_sts        sts;

    // register writes
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_limit      <= LIMIT_RST;
            r_query_timeout_us  <= TIMEOUT_RST;
            r_tombstone_keep_us <= KEEP_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_LIMIT:   r_active_limit      <= pwdata[4:0];
                REG_TIMEOUT: r_query_timeout_us  <= pwdata;
                REG_KEEP:    r_tombstone_keep_us <= pwdata;
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[3:2])
            REG_LIMIT:   prdata = {27'd0, r_active_limit};
            REG_TIMEOUT: prdata = r_query_timeout_us;
            REG_KEEP:    prdata = r_tombstone_keep_us;
            default:     prdata = 32'd0;
        endcase
    end

    dtm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    dtm_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TOMB_ENTRIES  (TOMB_ENTRIES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_txid              (i_txid),
        .i_resolver_addr     (i_resolver_addr),
        .i_client_addr       (i_client_addr),
        .i_client_port_num   (i_client_port_num),
        .i_partial_quality   (i_partial_quality),
        .i_rcode             (i_rcode),
        .i_truncated         (i_truncated),
        .i_malformed         (i_malformed),
        .i_now_us            (i_now_us),
        .i_new_epoch         (i_new_epoch),
        .i_active_limit      (r_active_limit),
        .i_query_timeout_us  (r_query_timeout_us),
        .i_tombstone_keep_us (r_tombstone_keep_us),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_kind              (o_kind),
        .o_match_txid        (o_match_txid),
        .o_latency_us        (o_latency_us),
        .o_attempts          (o_attempts),
        .o_generation        (o_generation),
        .o_partial_match     (o_partial_match),
        .o_expired_count     (o_expired_count),
        .o_last              (o_last)
    );
endmodule

// ===== rtl/dtm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/dtm_ctrl.sv =====
// Sequencing state machine of the match table: scans, decisions, result issue.
// Depends on dtm_pkg; drives the datapath through t_cmd and reads t_sts.
module dtm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [2:0]    i_op,
    input  dtm_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output dtm_pkg::t_cmd o_cmd
);
    import dtm_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_ES_Q     = 5'd1;
    localparam logic [4:0] S_Q_DEC    = 5'd2;
    localparam logic [4:0] S_TS_Q     = 5'd3;
    localparam logic [4:0] S_Q_INS    = 5'd4;
    localparam logic [4:0] S_ES_R     = 5'd5;
    localparam logic [4:0] S_R_DEC    = 5'd6;
    localparam logic [4:0] S_TS_R     = 5'd7;
    localparam logic [4:0] S_R_TOMB   = 5'd8;
    localparam logic [4:0] S_TS_PRUNE = 5'd9;
    localparam logic [4:0] S_SW_RD    = 5'd10;
    localparam logic [4:0] S_SW_CHK   = 5'd11;
    localparam logic [4:0] S_TS_PUT   = 5'd12;
    localparam logic [4:0] S_SW_PUT   = 5'd13;
    localparam logic [4:0] S_SW_DONE  = 5'd14;
    localparam logic [4:0] S_EPOCH    = 5'd15;
    localparam logic [4:0] S_CLEAR    = 5'd16;

    logic [4:0] r_state, n_state;
    t_cmd       cmd;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.cap = 1'b1;
                    unique case (i_op)
                        OP_QUERY:    n_state = S_ES_Q;
                        OP_RESPONSE: n_state = S_ES_R;
                        OP_SWEEP:    n_state = S_TS_PRUNE;
                        OP_EPOCH:    n_state = S_EPOCH;
                        OP_CLEAR:    n_state = S_CLEAR;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            // query: exact lookup, then retry, full or insert
            S_ES_Q: begin
                cmd.e_scan = 1'b1;
                if (i_sts.e_done) n_state = S_Q_DEC;
            end
            S_Q_DEC: begin
                if (i_sts.ex_hit) begin
                    if (i_sts.out_free) begin
                        cmd.act = ACT_RETRY;
                        n_state = S_IDLE;
                    end
                end else if (i_sts.full) begin
                    if (i_sts.out_free) begin
                        cmd.act = ACT_FULL;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_TS_Q;
                end
            end
            S_TS_Q: begin
                cmd.t_scan = 1'b1;
                if (i_sts.t_done) n_state = S_Q_INS;
            end
            S_Q_INS: begin
                if (i_sts.out_free) begin
                    cmd.act = ACT_NEW;
                    n_state = S_IDLE;
                end
            end
            // response: exact or unique wildcard match, ambiguous, else tombstone lookup
            S_ES_R: begin
                cmd.e_scan = 1'b1;
                if (i_sts.e_done) n_state = S_R_DEC;
            end
            S_R_DEC: begin
                if (i_sts.ex_hit || i_sts.cand_one) begin
                    if (i_sts.out_free) begin
                        cmd.act = ACT_RESP;
                        n_state = S_IDLE;
                    end
                end else if (i_sts.cand_multi) begin
                    if (i_sts.out_free) begin
                        cmd.act = ACT_AMBIG;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_TS_R;
                end
            end
            S_TS_R: begin
                cmd.t_scan = 1'b1;
                if (i_sts.t_done) n_state = S_R_TOMB;
            end
            S_R_TOMB: begin
                if (i_sts.out_free) begin
                    cmd.act = ACT_TOMBRES;
                    n_state = S_IDLE;
                end
            end
            // sweep: prune tombstones, then walk entries one by one
            S_TS_PRUNE: begin
                cmd.t_scan = 1'b1;
                cmd.prune  = 1'b1;
                if (i_sts.t_done) n_state = S_SW_RD;
            end
            S_SW_RD: begin
                cmd.sw_rd = 1'b1;
                n_state   = S_SW_CHK;
            end
            S_SW_CHK: begin
                cmd.sw_cap = 1'b1;
                if (i_sts.expire) begin
                    n_state = S_TS_PUT;
                end else begin
                    cmd.sw_inc = 1'b1;
                    n_state    = i_sts.sw_last ? S_SW_DONE : S_SW_RD;
                end
            end
            S_TS_PUT: begin
                cmd.t_scan = 1'b1;
                cmd.key_ex = 1'b1;
                if (i_sts.t_done) n_state = S_SW_PUT;
            end
            S_SW_PUT: begin
                if (i_sts.out_free) begin
                    cmd.act    = ACT_SWPUT;
                    cmd.sw_inc = 1'b1;
                    n_state    = i_sts.sw_last ? S_SW_DONE : S_SW_RD;
                end
            end
            S_SW_DONE: begin
                if (i_sts.out_free) begin
                    cmd.act = ACT_SWDONE;
                    n_state = S_IDLE;
                end
            end
            S_EPOCH: begin
                if (i_sts.out_free) begin
                    cmd.act = ACT_EPOCH;
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (i_sts.out_free) begin
                    cmd.act = ACT_CLEAR;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;
endmodule

// ===== rtl/dtm_datapath.sv =====
// Datapath of the match table: entry and tombstone stores, scan logic,
// request capture and the output register. Depends on dtm_pkg and dtm_ram.
module dtm_datapath #(
    parameter int TABLE_ENTRIES = dtm_pkg::TABLE_ENTRIES_DEF,
    parameter int TOMB_ENTRIES  = dtm_pkg::TOMB_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dtm_pkg::t_cmd i_cmd,
    output dtm_pkg::t_sts o_sts,
    // request fields
    input  logic [15:0]   i_txid,
    input  logic [31:0]   i_resolver_addr,
    input  logic [31:0]   i_client_addr,
    input  logic [15:0]   i_client_port_num,
    input  logic          i_partial_quality,
    input  logic [3:0]    i_rcode,
    input  logic          i_truncated,
    input  logic          i_malformed,
    input  logic [47:0]   i_now_us,
    input  logic [31:0]   i_new_epoch,
    // configuration
    input  logic [4:0]    i_active_limit,
    input  logic [31:0]   i_query_timeout_us,
    input  logic [31:0]   i_tombstone_keep_us,
    // result channel
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic [3:0]    o_kind,
    output logic [15:0]   o_match_txid,
    output logic [47:0]   o_latency_us,
    output logic [15:0]   o_attempts,
    output logic [31:0]   o_generation,
    output logic          o_partial_match,
    output logic [4:0]    o_expired_count,
    output logic          o_last
);
    import dtm_pkg::*;

    localparam int IW  = $clog2(TABLE_ENTRIES);
    localparam int EW  = $clog2(TABLE_ENTRIES + 1);
    localparam int TIW = $clog2(TOMB_ENTRIES);
    localparam int TW  = $clog2(TOMB_ENTRIES + 1);
    localparam logic [EW-1:0] E_END   = EW'(TABLE_ENTRIES);
    localparam logic [TW-1:0] T_END   = TW'(TOMB_ENTRIES);
    localparam logic [IW-1:0] SW_LAST = IW'(TABLE_ENTRIES - 1);

    // captured request
    t_key        r_key;
    logic        r_part, r_tc, r_mal;
    logic [3:0]  r_rcode;
    logic [47:0] r_now;
    logic [31:0] r_ne;

    // control state
    logic [TABLE_ENTRIES-1:0] r_ev;
    logic [TOMB_ENTRIES-1:0]  r_tv;
    logic [31:0]              r_ins;
    logic [31:0]              r_epoch;

    // scan state
    logic [EW-1:0]  r_ecnt;
    logic [TW-1:0]  r_tcnt;
    logic           r_ex_hit, r_free_hit, r_tm_hit, r_tf_hit;
    logic [IW-1:0]  r_ex_idx, r_cd_idx, r_free_idx, r_sw;
    logic [1:0]     r_cnt_c;
    logic [EW-1:0]  r_vcnt;
    t_entry         r_ex, r_cd;
    logic [TIW-1:0] r_tm_idx, r_tf_idx, r_old_idx;
    logic [47:0]    r_old_ts;
    logic [4:0]     r_exp;

    // output register
    logic        r_o_valid, r_last, r_opart;
    logic [3:0]  r_kind;
    logic [15:0] r_mtxid, r_att;
    logic [47:0] r_lat;
    logic [31:0] r_gen;
    logic [4:0]  r_oexp;

    logic [3:0]  n_kind;
    logic [15:0] n_mtxid, n_att;
    logic [47:0] n_lat;
    logic [31:0] n_gen;
    logic        n_part, n_last;
    logic [4:0]  n_exp;

    // RAM interface
    logic [$bits(t_entry)-1:0] e_rdata, e_wdata;
    logic [$bits(t_tomb)-1:0]  t_rdata, t_wdata;
    logic                      e_we, t_we;
    logic [IW-1:0]             e_waddr, e_raddr;
    logic [TIW-1:0]            t_waddr;
    t_entry                    ent_rd, sel_ent, new_ent, retry_ent;
    t_tomb                     tomb_rd;

    logic [EW-1:0]  e_pm1;
    logic [TW-1:0]  t_pm1;
    logic [IW-1:0]  e_pidx, sel_idx;
    logic [TIW-1:0] t_pidx, put_slot;
    logic           e_proc, t_proc, e_v, t_v, exact, cand, tmatch, prune_hit;
    logic           expire, out_free, epoch_gt;
    logic [15:0]    att_inc;
    logic [3:0]     resp_kind;
    t_key           tkey;

    dtm_ram #(.WIDTH($bits(t_entry)), .DEPTH(TABLE_ENTRIES)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    dtm_ram #(.WIDTH($bits(t_tomb)), .DEPTH(TOMB_ENTRIES)) u_tomb_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (r_tcnt[TIW-1:0]),
        .o_rdata (t_rdata)
    );

    assign ent_rd  = e_rdata;
    assign tomb_rd = t_rdata;
    assign e_raddr = i_cmd.sw_rd ? r_sw : r_ecnt[IW-1:0];

    // entry scan: read issued at count c, entry c-1 evaluated
    assign e_pm1  = r_ecnt - EW'(1);
    assign e_pidx = e_pm1[IW-1:0];
    assign e_proc = i_cmd.e_scan && (r_ecnt != '0);
    assign e_v    = r_ev[e_pidx];
    assign exact  = e_v && (ent_rd.key == r_key);
    assign cand   = e_v && (ent_rd.key.txid == r_key.txid)
                    && field_ok(r_key.res, ent_rd.key.res)
                    && field_ok(r_key.cli, ent_rd.key.cli)
                    && field_ok({16'd0, r_key.port}, {16'd0, ent_rd.key.port});

    // tombstone scan
    assign t_pm1     = r_tcnt - TW'(1);
    assign t_pidx    = t_pm1[TIW-1:0];
    assign t_proc    = i_cmd.t_scan && (r_tcnt != '0);
    assign t_v       = r_tv[t_pidx];
    assign tkey      = i_cmd.key_ex ? r_ex.key : r_key;
    assign tmatch    = t_v && (tomb_rd.key == tkey);
    assign prune_hit = i_cmd.prune && t_proc && t_v && (r_now >= tomb_rd.ts)
                       && ((r_now - tomb_rd.ts) > {16'd0, i_tombstone_keep_us});

    // sweep timeout check on the entry just read
    assign expire = r_ev[r_sw] && (r_now >= ent_rd.first)
                    && ((r_now - ent_rd.first) >= {16'd0, i_query_timeout_us});

    assign sel_ent  = r_ex_hit ? r_ex : r_cd;
    assign sel_idx  = r_ex_hit ? r_ex_idx : r_cd_idx;
    assign put_slot = r_tm_hit ? r_tm_idx : (r_tf_hit ? r_tf_idx : r_old_idx);
    assign out_free = !r_o_valid || !i_out_stall;
    assign epoch_gt = r_ne > r_epoch;
    assign att_inc  = (r_ex.att == 16'hFFFF) ? r_ex.att : (r_ex.att + 16'd1);

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_key   <= '{txid: i_txid, res: i_resolver_addr, cli: i_client_addr,
                         port: i_client_port_num};
            r_part  <= i_partial_quality;
            r_rcode <= i_rcode;
            r_tc    <= i_truncated;
            r_mal   <= i_malformed;
            r_now   <= i_now_us;
            r_ne    <= i_new_epoch;
        end
    end

    // scan counters and accumulators
    always_ff @(posedge i_clk) begin
        r_ecnt <= i_cmd.e_scan ? (r_ecnt + EW'(1)) : '0;
        r_tcnt <= i_cmd.t_scan ? (r_tcnt + TW'(1)) : '0;

        if (i_cmd.e_scan && (r_ecnt == '0)) begin
            r_ex_hit   <= 1'b0;
            r_free_hit <= 1'b0;
            r_cnt_c    <= 2'd0;
            r_vcnt     <= '0;
        end else if (e_proc) begin
            if (exact && !r_ex_hit) begin
                r_ex_hit <= 1'b1;
                r_ex_idx <= e_pidx;
                r_ex     <= ent_rd;
            end
            if (cand) begin
                r_cd_idx <= e_pidx;
                r_cd     <= ent_rd;
                if (r_cnt_c != 2'd2) r_cnt_c <= r_cnt_c + 2'd1;
            end
            if (e_v) begin
                r_vcnt <= r_vcnt + EW'(1);
            end else if (!r_free_hit) begin
                r_free_hit <= 1'b1;
                r_free_idx <= e_pidx;
            end
        end else if (i_cmd.sw_cap) begin
            r_ex <= ent_rd;
        end

        if (i_cmd.t_scan && (r_tcnt == '0)) begin
            r_tm_hit <= 1'b0;
            r_tf_hit <= 1'b0;
        end else if (t_proc) begin
            if (tmatch && !r_tm_hit) begin
                r_tm_hit <= 1'b1;
                r_tm_idx <= t_pidx;
            end
            if (!t_v && !r_tf_hit) begin
                r_tf_hit <= 1'b1;
                r_tf_idx <= t_pidx;
            end
            // oldest slot, lowest index on ties
            if ((t_pidx == '0) || (tomb_rd.ts < r_old_ts)) begin
                r_old_idx <= t_pidx;
                r_old_ts  <= tomb_rd.ts;
            end
        end

        // sweep walk
        if (i_cmd.cap) begin
            r_sw  <= '0;
            r_exp <= 5'd0;
        end else begin
            if (i_cmd.sw_inc) r_sw <= r_sw + IW'(1);
            if (i_cmd.act == ACT_SWPUT) r_exp <= r_exp + 5'd1;
        end
    end

    // valid bits, insert counter, epoch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev    <= '0;
            r_tv    <= '0;
            r_ins   <= 32'd0;
            r_epoch <= 32'd0;
        end else begin
            if (prune_hit) r_tv[t_pidx] <= 1'b0;
            case (i_cmd.act)
                ACT_NEW: begin
                    r_ev[r_free_idx] <= 1'b1;
                    if (r_tm_hit) r_tv[r_tm_idx] <= 1'b0;
                    r_ins <= r_ins + 32'd1;
                end
                ACT_RESP: r_ev[sel_idx] <= 1'b0;
                ACT_SWPUT: begin
                    r_ev[r_sw]     <= 1'b0;
                    r_tv[put_slot] <= 1'b1;
                end
                ACT_EPOCH: begin
                    if (epoch_gt) begin
                        r_epoch <= r_ne;
                        r_ev    <= '0;
                        r_tv    <= '0;
                    end
                end
                ACT_CLEAR: begin
                    r_ev <= '0;
                    r_tv <= '0;
                end
                default: ;
            endcase
        end
    end

    // store writes
    always_comb begin
        new_ent   = '{key: r_key, first: r_now, att: 16'd1, part: r_part,
                      gen: r_ins + 32'd1};
        retry_ent = r_ex;
        retry_ent.att = att_inc;
        e_we    = (i_cmd.act == ACT_NEW) || (i_cmd.act == ACT_RETRY);
        e_waddr = (i_cmd.act == ACT_NEW) ? r_free_idx : r_ex_idx;
        e_wdata = (i_cmd.act == ACT_NEW) ? new_ent : retry_ent;
        t_we    = (i_cmd.act == ACT_SWPUT);
        t_waddr = put_slot;
        t_wdata = t_tomb'{key: r_ex.key, ts: r_now};
    end

    // response class: malformed, then truncated, then rcode
    always_comb begin
        if (r_mal) begin
            resp_kind = KIND_OTHER;
        end else if (r_tc) begin
            resp_kind = KIND_TRUNC;
        end else begin
            case (r_rcode)
                RCODE_NOERROR:  resp_kind = KIND_NOERROR;
                RCODE_SERVFAIL: resp_kind = KIND_SERVFAIL;
                RCODE_NXDOMAIN: resp_kind = KIND_NXDOMAIN;
                RCODE_REFUSED:  resp_kind = KIND_REFUSED;
                default:        resp_kind = KIND_OTHER;
            endcase
        end
    end

    // next result
    always_comb begin
        n_kind  = KIND_EPOCH_IGN;
        n_mtxid = 16'd0;
        n_lat   = 48'd0;
        n_att   = 16'd0;
        n_gen   = 32'd0;
        n_part  = 1'b0;
        n_exp   = 5'd0;
        n_last  = 1'b1;
        case (i_cmd.act)
            ACT_RETRY: begin
                n_kind  = KIND_RETRY;
                n_mtxid = r_ex.key.txid;
                n_lat   = age_of(r_now, r_ex.first);
                n_att   = att_inc;
                n_gen   = r_ex.gen;
                n_part  = r_ex.part;
            end
            ACT_FULL: begin
                n_kind  = KIND_FULL;
                n_mtxid = r_key.txid;
            end
            ACT_NEW: begin
                n_kind  = KIND_NEW;
                n_mtxid = r_key.txid;
                n_att   = 16'd1;
                n_gen   = r_ins + 32'd1;
                n_part  = r_part;
            end
            ACT_RESP: begin
                n_kind  = resp_kind;
                n_mtxid = sel_ent.key.txid;
                n_lat   = age_of(r_now, sel_ent.first);
                n_att   = sel_ent.att;
                n_gen   = sel_ent.gen;
                n_part  = sel_ent.part;
            end
            ACT_AMBIG: begin
                n_kind  = KIND_AMBIG;
                n_mtxid = r_key.txid;
            end
            ACT_TOMBRES: begin
                n_kind  = r_tm_hit ? KIND_LATE : KIND_UNMATCHED;
                n_mtxid = r_key.txid;
            end
            ACT_SWPUT: begin
                n_kind  = KIND_TIMEOUT;
                n_mtxid = r_ex.key.txid;
                n_lat   = r_now - r_ex.first;
                n_att   = r_ex.att;
                n_gen   = r_ex.gen;
                n_part  = r_ex.part;
                n_last  = 1'b0;
            end
            ACT_SWDONE: begin
                n_kind = KIND_SWEEPDONE;
                n_exp  = r_exp;
            end
            ACT_EPOCH: n_kind = epoch_gt ? KIND_EPOCH_ADV : KIND_EPOCH_IGN;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.act != ACT_NONE) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act != ACT_NONE) begin
            r_kind  <= n_kind;
            r_mtxid <= n_mtxid;
            r_lat   <= n_lat;
            r_att   <= n_att;
            r_gen   <= n_gen;
            r_opart <= n_part;
            r_oexp  <= n_exp;
            r_last  <= n_last;
        end
    end

    // status to controller
    assign o_sts.out_free   = out_free;
    assign o_sts.e_done     = i_cmd.e_scan && (r_ecnt == E_END);
    assign o_sts.t_done     = i_cmd.t_scan && (r_tcnt == T_END);
    assign o_sts.ex_hit     = r_ex_hit;
    assign o_sts.cand_one   = (r_cnt_c == 2'd1);
    assign o_sts.cand_multi = (r_cnt_c == 2'd2);
    assign o_sts.full       = (8'(r_vcnt) >= 8'(i_active_limit)) || (r_vcnt == E_END);
    assign o_sts.expire     = expire;
    assign o_sts.sw_last    = (r_sw == SW_LAST);

    assign o_out_valid     = r_o_valid;
    assign o_kind          = r_kind;
    assign o_match_txid    = r_mtxid;
    assign o_latency_us    = r_lat;
    assign o_attempts      = r_att;
    assign o_generation    = r_gen;
    assign o_partial_match = r_opart;
    assign o_expired_count = r_oexp;
    assign o_last          = r_last;

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.act != ACT_NONE) |-> out_free)
        else $error("result loaded over a pending result");

    // an insert always has a free slot from the preceding scan
    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.act == ACT_NEW) |-> r_free_hit)
        else $error("insert without a free slot");

    // a matched response has an exact hit or a single wildcard candidate
    a_resp_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.act == ACT_RESP) |-> (r_ex_hit || (r_cnt_c == 2'd1)))
        else $error("response claimed without a unique match");

    // a timed-out entry is gone after its result
    a_timeout_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.act == ACT_SWPUT) |=> !r_ev[$past(r_sw)])
        else $error("timed-out entry still valid");
endmodule
